/* hdl/crg_pkg.sv */
// Shared types, register indexes and constants of the camera ray generator.
package crg_pkg;

	localparam int IMAGE_WIDTH_DEF  = 1024;
	localparam int IMAGE_HEIGHT_DEF = 768;

	localparam int PIX_W      = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] CFG_BASIS_U  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASIS_V  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASIS_W  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CAM_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CAM_Z    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT = 3'd6;

	localparam logic [47:0] BASIS_U_RST  = 48'h0000_0000_4000;
	localparam logic [47:0] BASIS_V_RST  = 48'h0000_4000_0000;
	localparam logic [47:0] BASIS_W_RST  = 48'h4000_0000_0000;
	localparam logic [47:0] VIEWPORT_RST = 48'h0100_0100_0100;

	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	// plane divider: quotient bits per stage; direction divider likewise
	localparam int PLANE_BPS = 4;
	localparam int DIR_BPS   = 2;

	// the largest normalized magnitude lies in [2^29, 2^30)
	localparam int NORM_MSB = 29;
	localparam int NRM_W    = 30;
	localparam int SQ_W     = 2 * NRM_W;
	localparam int SUMSQ_W  = SQ_W + 2;
	localparam int ROOT_W   = SUMSQ_W / 2;
	localparam int DQ_W     = 15;
	localparam int DNUM_W   = NRM_W + 15;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_row;
		logic [PIX_W-1:0] pixel_col;
	} pixel_t;

	typedef struct packed {
		logic        zero_length;
		logic signed [15:0] ray_dir_z;
		logic signed [15:0] ray_dir_y;
		logic signed [15:0] ray_dir_x;
		logic signed [31:0] ray_origin_z;
		logic signed [31:0] ray_origin_y;
		logic signed [31:0] ray_origin_x;
	} ray_t;

endpackage

/* hdl/crg_div.sv */
// Pipelined restoring divider, BPS quotient bits per stage.
module crg_div #(
	parameter int NW  = 45,
	parameter int DW  = 31,
	parameter int QW  = 15,
	parameter int BPS = 2
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int LAT = (QW + BPS - 1) / BPS;

	logic [DW-1:0] rem_s [LAT];
	logic [QW-1:0] low_s [LAT];
	logic [QW-1:0] q_s   [LAT];
	logic [DW-1:0] den_s [LAT];
	logic [DW-1:0] rem0;

	// upper numerator bits are known to sit below den
	generate
		if (NW > QW) begin : g_pre
			assign rem0 = DW'(num[NW-1:QW]);
		end else begin : g_nopre
			assign rem0 = '0;
		end
	endgenerate

	genvar i;
	generate
		for (i = 0; i < LAT; i++) begin : g_stage
			logic [DW-1:0] r_in, r_c, d_in;
			logic [QW-1:0] l_in, l_c, q_in, q_c;
			logic [DW:0]   t;

			if (i == 0) begin : g_first
				assign r_in = rem0;
				assign l_in = num[QW-1:0];
				assign q_in = '0;
				assign d_in = den;
			end else begin : g_next
				assign r_in = rem_s[i-1];
				assign l_in = low_s[i-1];
				assign q_in = q_s[i-1];
				assign d_in = den_s[i-1];
			end

			always_comb begin
				r_c = r_in;
				l_c = l_in;
				q_c = q_in;
				t   = '0;
				for (int b = 0; b < BPS; b++) begin
					if (i * BPS + b < QW) begin
						t = {r_c, l_c[QW-1]};
						if (t >= {1'b0, d_in}) begin
							r_c = DW'(t - {1'b0, d_in});
							q_c = {q_c[QW-2:0], 1'b1};
						end else begin
							r_c = t[DW-1:0];
							q_c = {q_c[QW-2:0], 1'b0};
						end
						l_c = {l_c[QW-2:0], 1'b0};
					end
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= r_c;
					low_s[i] <= l_c;
					q_s[i]   <= q_c;
					den_s[i] <= d_in;
				end
			end
		end
	endgenerate

	assign quo = q_s[LAT-1];

endmodule

/* hdl/crg_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module crg_sqrt #(
	parameter int W = 62
) (
	input  logic            clk,
	input  logic            en,
	input  logic [W-1:0]    rad,
	output logic [W/2-1:0]  root
);

	localparam int LAT = W / 2;

	logic [W-1:0] n_s [LAT];
	logic [W-1:0] r_s [LAT];

	genvar i;
	generate
		for (i = 0; i < LAT; i++) begin : g_stage
			localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * i);
			logic [W-1:0] n_in, r_in, n_c, r_c;
			logic [W:0]   trial;

			if (i == 0) begin : g_first
				assign n_in = rad;
				assign r_in = '0;
			end else begin : g_next
				assign n_in = n_s[i-1];
				assign r_in = r_s[i-1];
			end

			always_comb begin
				trial = {1'b0, r_in} + {1'b0, BIT};
				if ({1'b0, n_in} >= trial) begin
					n_c = n_in - trial[W-1:0];
					r_c = (r_in >> 1) + BIT;
				end else begin
					n_c = n_in;
					r_c = r_in >> 1;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					n_s[i] <= n_c;
					r_s[i] <= r_c;
				end
			end
		end
	endgenerate

	assign root = r_s[LAT-1][W/2-1:0];

endmodule

/* hdl/camera_primary_ray_generator_top.sv */
// Top level of the pinhole camera primary ray generator pipeline.
//
// Pixel words (column, row) enter on pixel/pixel_valid/pixel_ready; one ray
// word per pixel leaves on ray/ray_valid/ray_ready, in order. The camera
// basis, position and viewport shape are set through cfg_we/cfg_index/
// cfg_data, one register per cycle; the user must write them only while no
// pixel is in flight, which the block does not enforce. Throughput is one
// pixel per cycle while the output is not stalled. Stages: 3 input stages,
// the plane divider (4 quotient bits a stage, wider for a taller image), 9
// stages of basis products, origin and normalization, the 31-stage square
// root, a numerator stage, the 8-stage direction divider, output register.
// The whole pipeline advances together: when a ray word sits unaccepted at
// the output, pixel_ready drops and every stage holds; nothing is lost.
// Reset clears all valid bits and loads the default basis (identity),
// a camera at the origin and a 1.0 x 1.0 viewport at distance 1.0.
module camera_primary_ray_generator_top #(
	parameter int IMAGE_WIDTH  = crg_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = crg_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  crg_pkg::pixel_t                 pixel,
	input  logic                            pixel_valid,
	output logic                            pixel_ready,
	output crg_pkg::ray_t                   ray,
	output logic                            ray_valid,
	input  logic                            ray_ready,
	input  logic                            cfg_we,
	input  logic [crg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [crg_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW_W  = $clog2(IMAGE_WIDTH);
	localparam int CH_W  = $clog2(IMAGE_HEIGHT);
	localparam int DEN_W = (CW_W > CH_W) ? CW_W : CH_W;
	localparam int HR_A  = $clog2(IMAGE_HEIGHT + 1) + 1;
	localparam int HROW_W = (HR_A > crg_pkg::PIX_W + 1) ? HR_A : crg_pkg::PIX_W + 1;
	localparam int PH_W   = HROW_W + 17;
	localparam int PN_W   = HROW_W + 24;
	localparam int HV_W   = PN_W + 2;
	localparam int PROD_W = HV_W + 16;
	localparam int S_W    = PROD_W + 2;
	localparam int RQ_W   = S_W - 13;
	localparam int RN_W   = S_W - 12;
	localparam int SUM_W  = S_W - 11;
	localparam int G      = (S_W + 7) / 8;
	localparam int P_W    = $clog2(G * 8);
	localparam int LD     = (PN_W + crg_pkg::PLANE_BPS - 1) / crg_pkg::PLANE_BPS;
	localparam int LS     = crg_pkg::SUMSQ_W / 2;
	localparam int LQ     = (crg_pkg::DQ_W + crg_pkg::DIR_BPS - 1) / crg_pkg::DIR_BPS;

	localparam logic [DEN_W-1:0] DEN_H  = DEN_W'(IMAGE_WIDTH - 1);
	localparam logic [DEN_W-1:0] DEN_V  = DEN_W'(IMAGE_HEIGHT - 1);
	localparam logic [PN_W-1:0]  HALF_H = PN_W'((IMAGE_WIDTH - 1) / 2);
	localparam logic [PN_W-1:0]  HALF_V = PN_W'((IMAGE_HEIGHT - 1) / 2);
	localparam logic signed [HROW_W-1:0] IMG_H = HROW_W'(IMAGE_HEIGHT);

	typedef struct packed {
		logic [2:0][crg_pkg::NRM_W-1:0] nm;
		logic        zero;
		logic [2:0]  sneg;
		logic [2:0][31:0] org;
	} side_b_t;

	typedef struct packed {
		logic        zero;
		logic [2:0]  sneg;
		logic [2:0][31:0] org;
	} side_c_t;

	// configuration
	logic [47:0] basis_u_q, basis_v_q, basis_w_q, viewport_q;
	logic [2:0][31:0] pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_u_q  <= crg_pkg::BASIS_U_RST;
			basis_v_q  <= crg_pkg::BASIS_V_RST;
			basis_w_q  <= crg_pkg::BASIS_W_RST;
			viewport_q <= crg_pkg::VIEWPORT_RST;
			pos_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				crg_pkg::CFG_BASIS_U:  basis_u_q  <= cfg_data;
				crg_pkg::CFG_BASIS_V:  basis_v_q  <= cfg_data;
				crg_pkg::CFG_BASIS_W:  basis_w_q  <= cfg_data;
				crg_pkg::CFG_CAM_X:    pos_q[0]   <= cfg_data[31:0];
				crg_pkg::CFG_CAM_Y:    pos_q[1]   <= cfg_data[31:0];
				crg_pkg::CFG_CAM_Z:    pos_q[2]   <= cfg_data[31:0];
				crg_pkg::CFG_VIEWPORT: viewport_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [15:0] vw, vh, vd;
	assign vw = viewport_q[15:0];
	assign vh = viewport_q[31:16];
	assign vd = viewport_q[47:32];

	logic en;
	assign en          = !ray_valid || ray_ready;
	assign pixel_ready = en;

	// valid bits
	logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13;
	logic va [LD];
	logic vb [LS];
	logic vc [LQ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
			v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0;
			v11 <= 1'b0; v12 <= 1'b0; v13 <= 1'b0; ray_valid <= 1'b0;
			for (int i = 0; i < LD; i++) va[i] <= 1'b0;
			for (int i = 0; i < LS; i++) vb[i] <= 1'b0;
			for (int i = 0; i < LQ; i++) vc[i] <= 1'b0;
		end else if (en) begin
			v1 <= pixel_valid;
			v2 <= v1;
			v3 <= v2;
			va[0] <= v3;
			for (int i = 1; i < LD; i++) va[i] <= va[i-1];
			v4 <= va[LD-1];
			v5 <= v4;
			v6 <= v5;
			v7 <= v6;
			v8 <= v7;
			v9 <= v8;
			v10 <= v9;
			v11 <= v10;
			v12 <= v11;
			vb[0] <= v12;
			for (int i = 1; i < LS; i++) vb[i] <= vb[i-1];
			v13 <= vb[LS-1];
			vc[0] <= v13;
			for (int i = 1; i < LQ; i++) vc[i] <= vc[i-1];
			ray_valid <= vc[LQ-1];
		end
	end

	// s1..s3: plane numerators
	logic [crg_pkg::PIX_W-1:0] col_s1, row_s1;
	logic [25:0]               pw_s2;
	logic signed [PH_W-1:0]    ph_s2;
	logic [PN_W-1:0]           numh_s3, numv_s3;
	logic                      negv_s3;
	logic signed [HROW_W-1:0]  hrow;
	logic [PH_W-1:0]           phmag;

	assign hrow  = IMG_H - $signed({{(HROW_W - crg_pkg::PIX_W){1'b0}}, row_s1});
	assign phmag = ph_s2[PH_W-1] ? PH_W'(-ph_s2) : PH_W'(ph_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1  <= pixel.pixel_col;
			row_s1  <= pixel.pixel_row;
			pw_s2   <= vw * col_s1;
			ph_s2   <= $signed({1'b0, vh}) * hrow;
			numh_s3 <= PN_W'({pw_s2, 8'b0}) + HALF_H;
			numv_s3 <= PN_W'({phmag, 8'b0}) + HALF_V;
			negv_s3 <= ph_s2[PH_W-1];
		end
	end

	logic [PN_W-1:0] qh, qv;
	logic            negv_d [LD];

	crg_div #(.NW(PN_W), .DW(DEN_W), .QW(PN_W), .BPS(crg_pkg::PLANE_BPS)) u_div_h (
		.clk(clk), .en(en), .num(numh_s3), .den(DEN_H), .quo(qh)
	);

	crg_div #(.NW(PN_W), .DW(DEN_W), .QW(PN_W), .BPS(crg_pkg::PLANE_BPS)) u_div_v (
		.clk(clk), .en(en), .num(numv_s3), .den(DEN_V), .quo(qv)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			negv_d[0] <= negv_s3;
			for (int i = 1; i < LD; i++) negv_d[i] <= negv_d[i-1];
		end
	end

	// s4: plane values, s5: basis products, s6: direction sum
	logic signed [HV_W-1:0]   horiz_s4, vert_s4, depth;
	logic signed [HV_W-1:0]   qv_ext;
	logic signed [PROD_W-1:0] pu_s5 [3];
	logic signed [PROD_W-1:0] pv_s5 [3];
	logic signed [PROD_W-1:0] pw_s5 [3];
	logic signed [S_W-1:0]    s_s6 [3];

	assign qv_ext = $signed({2'b0, qv});
	assign depth  = $signed({{(HV_W - 24){1'b0}}, vd, 8'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			horiz_s4 <= $signed({2'b0, qh}) - $signed({{(HV_W - 23){1'b0}}, vw, 7'b0});
			vert_s4  <= (negv_d[LD-1] ? -qv_ext : qv_ext)
				- $signed({{(HV_W - 23){1'b0}}, vh, 7'b0});
			for (int k = 0; k < 3; k++) begin
				pu_s5[k] <= $signed(basis_u_q[16*k +: 16]) * depth;
				pv_s5[k] <= $signed(basis_v_q[16*k +: 16]) * vert_s4;
				pw_s5[k] <= $signed(basis_w_q[16*k +: 16]) * horiz_s4;
				s_s6[k]  <= pu_s5[k] + pv_s5[k] + pw_s5[k];
			end
		end
	end

	// s7: magnitudes; s8: leading-one groups, rounded origin; s9: position, saturate
	logic [S_W-1:0]          mag_s7 [3];
	logic [S_W-1:0]          mag_s8 [3];
	logic [S_W-1:0]          mag_s9 [3];
	logic [2:0]              sneg_s7, sneg_s8, sneg_s9, sneg_s10, sneg_s11, sneg_s12;
	logic                    or_s7, zero_s8, zero_s9, zero_s10, zero_s11, zero_s12;
	logic [G-1:0]            nz_s8, nz_c;
	logic [2:0]              lp_s8 [G];
	logic [2:0]              lp_c [G];
	logic signed [RN_W-1:0]  ron_s8 [3];
	logic signed [RN_W-1:0]  ron_c [3];
	logic [P_W-1:0]          p_s9, p_c;
	logic [2:0][31:0]        org_s9, org_s10, org_s11, org_s12, org_c;
	logic signed [SUM_W-1:0] osum [3];
	logic [G*8-1:0]          orp;
	logic [S_W:0]            rnd [3];
	logic [RQ_W-1:0]         rq [3];

	assign orp = (G * 8)'(mag_s7[0] | mag_s7[1] | mag_s7[2]);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			// divide by 2^14, half away from zero
			rnd[k]   = {1'b0, mag_s7[k]} + (S_W + 1)'(8192);
			rq[k]    = rnd[k][S_W:14];
			ron_c[k] = sneg_s7[k] ? -$signed({1'b0, rq[k]}) : $signed({1'b0, rq[k]});
		end
		for (int g = 0; g < G; g++) begin
			nz_c[g] = |orp[8*g +: 8];
			lp_c[g] = '0;
			for (int b = 0; b < 8; b++) begin
				if (orp[8*g + b]) lp_c[g] = 3'(b);
			end
		end
	end

	always_comb begin
		p_c = '0;
		for (int g = 0; g < G; g++) begin
			if (nz_s8[g]) p_c = P_W'(8 * g) | P_W'(lp_s8[g]);
		end
		for (int k = 0; k < 3; k++) begin
			osum[k] = ron_s8[k] + $signed(pos_q[k]);
			if (osum[k][SUM_W-1:31] == '0 || osum[k][SUM_W-1:31] == '1) begin
				org_c[k] = osum[k][31:0];
			end else if (osum[k][SUM_W-1]) begin
				org_c[k] = crg_pkg::SAT_MIN;
			end else begin
				org_c[k] = crg_pkg::SAT_MAX;
			end
		end
	end

	// s10: shift so the largest magnitude lands in [2^29, 2^30)
	// s11: squares, s12: sum of squares
	logic [crg_pkg::NRM_W-1:0]   nm_s10 [3];
	logic [crg_pkg::NRM_W-1:0]   nm_s11 [3];
	logic [crg_pkg::NRM_W-1:0]   nm_s12 [3];
	logic [crg_pkg::SQ_W-1:0]    sq_s11 [3];
	logic [crg_pkg::SUMSQ_W-1:0] n2_s12;
	logic [crg_pkg::NRM_W-1:0]   nm_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (p_s9 >= P_W'(crg_pkg::NORM_MSB)) begin
				nm_c[k] = crg_pkg::NRM_W'(mag_s9[k] >> (p_s9 - P_W'(crg_pkg::NORM_MSB)));
			end else begin
				nm_c[k] = crg_pkg::NRM_W'(mag_s9[k] << (P_W'(crg_pkg::NORM_MSB) - p_s9));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				mag_s7[k]  <= s_s6[k][S_W-1] ? S_W'(-s_s6[k]) : S_W'(s_s6[k]);
				sneg_s7[k] <= s_s6[k][S_W-1];
				mag_s8[k]  <= mag_s7[k];
				ron_s8[k]  <= ron_c[k];
				mag_s9[k]  <= mag_s8[k];
				nm_s10[k]  <= nm_c[k];
				nm_s11[k]  <= nm_s10[k];
				sq_s11[k]  <= nm_s10[k] * nm_s10[k];
				nm_s12[k]  <= nm_s11[k];
			end
			or_s7    <= |(s_s6[0] | s_s6[1] | s_s6[2]);
			sneg_s8  <= sneg_s7;
			zero_s8  <= ~or_s7;
			nz_s8    <= nz_c;
			lp_s8    <= lp_c;
			sneg_s9  <= sneg_s8;
			zero_s9  <= zero_s8;
			p_s9     <= p_c;
			org_s9   <= org_c;
			sneg_s10 <= sneg_s9;
			zero_s10 <= zero_s9;
			org_s10  <= org_s9;
			sneg_s11 <= sneg_s10;
			zero_s11 <= zero_s10;
			org_s11  <= org_s10;
			sneg_s12 <= sneg_s11;
			zero_s12 <= zero_s11;
			org_s12  <= org_s11;
			n2_s12   <= crg_pkg::SUMSQ_W'(sq_s11[0]) + crg_pkg::SUMSQ_W'(sq_s11[1])
				+ crg_pkg::SUMSQ_W'(sq_s11[2]);
		end
	end

	// square root of the normalized length
	logic [crg_pkg::ROOT_W-1:0] nrm;
	side_b_t                    sb [LS];

	crg_sqrt #(.W(crg_pkg::SUMSQ_W)) u_sqrt (
		.clk(clk), .en(en), .rad(n2_s12), .root(nrm)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) sb[0].nm[k] <= nm_s12[k];
			sb[0].zero <= zero_s12;
			sb[0].sneg <= sneg_s12;
			sb[0].org  <= org_s12;
			for (int i = 1; i < LS; i++) sb[i] <= sb[i-1];
		end
	end

	// s13: direction numerators, then three dividers sharing the norm
	logic [crg_pkg::DNUM_W-1:0] dnum_s13 [3];
	logic [crg_pkg::ROOT_W-1:0] nrm_s13;
	side_c_t                    sc_s13;
	side_c_t                    sc [LQ];
	logic [crg_pkg::DQ_W-1:0]   dq [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dnum_s13[k] <= {1'b0, sb[LS-1].nm[k], 14'b0}
					+ crg_pkg::DNUM_W'(nrm >> 1);
			end
			nrm_s13     <= nrm;
			sc_s13.zero <= sb[LS-1].zero;
			sc_s13.sneg <= sb[LS-1].sneg;
			sc_s13.org  <= sb[LS-1].org;
			sc[0]       <= sc_s13;
			for (int i = 1; i < LQ; i++) sc[i] <= sc[i-1];
		end
	end

	genvar gk;
	generate
		for (gk = 0; gk < 3; gk++) begin : g_dir
			crg_div #(
				.NW(crg_pkg::DNUM_W), .DW(crg_pkg::ROOT_W),
				.QW(crg_pkg::DQ_W), .BPS(crg_pkg::DIR_BPS)
			) u_div_d (
				.clk(clk), .en(en), .num(dnum_s13[gk]), .den(nrm_s13), .quo(dq[gk])
			);
		end
	endgenerate

	// output register
	logic [15:0] dir_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (sc[LQ-1].zero) begin
				dir_c[k] = '0;
			end else if (sc[LQ-1].sneg[k]) begin
				dir_c[k] = -{1'b0, dq[k]};
			end else begin
				dir_c[k] = {1'b0, dq[k]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray.ray_origin_x <= sc[LQ-1].org[0];
			ray.ray_origin_y <= sc[LQ-1].org[1];
			ray.ray_origin_z <= sc[LQ-1].org[2];
			ray.ray_dir_x    <= dir_c[0];
			ray.ray_dir_y    <= dir_c[1];
			ray.ray_dir_z    <= dir_c[2];
			ray.zero_length  <= sc[LQ-1].zero;
		end
	end

endmodule

/* tb/tb_top.sv */
// Testbench for the camera primary ray generator: directed and random pixels checked in order.
`timescale 1ns / 1ps

class ray_scoreboard;
	logic [47:0] bu, bv, bw, vp;
	logic [31:0] cx, cy, cz;
	crg_pkg::ray_t pending_rays[$];
	int mismatches;

	function new();
		bu = crg_pkg::BASIS_U_RST;
		bv = crg_pkg::BASIS_V_RST;
		bw = crg_pkg::BASIS_W_RST;
		vp = crg_pkg::VIEWPORT_RST;
		cx = 0;
		cy = 0;
		cz = 0;
		mismatches = 0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [47:0] d);
		case (idx)
			crg_pkg::CFG_BASIS_U: bu = d;
			crg_pkg::CFG_BASIS_V: bv = d;
			crg_pkg::CFG_BASIS_W: bw = d;
			crg_pkg::CFG_CAM_X: cx = d[31:0];
			crg_pkg::CFG_CAM_Y: cy = d[31:0];
			crg_pkg::CFG_CAM_Z: cz = d[31:0];
			crg_pkg::CFG_VIEWPORT: vp = d;
			default: ;
		endcase
	endfunction

	// divide rounding half away from zero
	function longint round_div(longint num, longint den);
		longint q;
		q = ((num < 0 ? -num : num) + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function void note_pixel(crg_pkg::pixel_t p);
		crg_pkg::ray_t r;
		longint h, vt, dp, o, s[3], pos[3];
		longint unsigned mg[3], m, nrm, q;
		h = round_div(longint'(vp[15:0]) * p.pixel_col * 256, 1023) - longint'(vp[15:0]) * 128;
		vt = round_div(longint'(vp[31:16]) * (768 - longint'(p.pixel_row)) * 256, 767)
			- longint'(vp[31:16]) * 128;
		dp = longint'(vp[47:32]) * 256;
		for (int k = 0; k < 3; k++)
			s[k] = longint'($signed(bu[16*k +: 16])) * dp
				+ longint'($signed(bv[16*k +: 16])) * vt
				+ longint'($signed(bw[16*k +: 16])) * h;
		pos[0] = longint'($signed(cx));
		pos[1] = longint'($signed(cy));
		pos[2] = longint'($signed(cz));
		m = 0;
		for (int k = 0; k < 3; k++) begin
			o = round_div(s[k], 16384) + pos[k];
			if (o > 64'sd2147483647) o = 64'sd2147483647;
			if (o < -64'sd2147483648) o = -64'sd2147483648;
			if (k == 0) r.ray_origin_x = o[31:0];
			if (k == 1) r.ray_origin_y = o[31:0];
			if (k == 2) r.ray_origin_z = o[31:0];
			mg[k] = s[k] < 0 ? -s[k] : s[k];
			if (mg[k] > m) m = mg[k];
		end
		r.ray_dir_x = 0;
		r.ray_dir_y = 0;
		r.ray_dir_z = 0;
		r.zero_length = (m == 0);
		if (m != 0) begin
			while (m >= (64'd1 << 30)) begin
				m >>= 1;
				for (int k = 0; k < 3; k++) mg[k] >>= 1;
			end
			while (m < (64'd1 << 29)) begin
				m <<= 1;
				for (int k = 0; k < 3; k++) mg[k] <<= 1;
			end
			nrm = int_sqrt(mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2]);
			for (int k = 0; k < 3; k++) begin
				q = (mg[k] * 16384 + nrm / 2) / nrm;
				if (s[k] < 0) q = -q;
				if (k == 0) r.ray_dir_x = q[15:0];
				if (k == 1) r.ray_dir_y = q[15:0];
				if (k == 2) r.ray_dir_z = q[15:0];
			end
		end
		pending_rays.push_back(r);
	endfunction

	function void check_ray(crg_pkg::ray_t got);
		crg_pkg::ray_t want;
		if (pending_rays.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected ray word %h", got);
			return;
		end
		want = pending_rays.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ray mismatch: expected org %h %h %h dir %h %h %h z %b, got org %h %h %h dir %h %h %h z %b",
					want.ray_origin_x, want.ray_origin_y, want.ray_origin_z,
					want.ray_dir_x, want.ray_dir_y, want.ray_dir_z, want.zero_length,
					got.ray_origin_x, got.ray_origin_y, got.ray_origin_z,
					got.ray_dir_x, got.ray_dir_y, got.ray_dir_z, got.zero_length);
		end
	endfunction
endclass

module tb_top;

	logic clk, arst_n;
	crg_pkg::pixel_t pixel;
	logic pixel_valid, pixel_ready;
	crg_pkg::ray_t ray;
	logic ray_valid, ray_ready;
	logic cfg_we;
	logic [crg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [crg_pkg::CFG_DATA_W-1:0] cfg_data;

	int send_idle_pct, stall_pct;
	longint cycles;
	ray_scoreboard sb;

	camera_primary_ray_generator_top dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("tb: failure");
			$finish;
		end
		if (arst_n && ray_valid && ray_ready) sb.check_ray(ray);
		if (arst_n && pixel_valid && pixel_ready) sb.note_pixel(pixel);
	end

	// receiver stalls
	always @(negedge clk)
		ray_ready <= ($urandom_range(99) >= stall_pct);

	// valid stays up after a word so back-to-back words need no gap
	task automatic send_pixel(logic [9:0] col, logic [9:0] row);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 0;
			@(negedge clk);
		end
		pixel_valid <= 1;
		pixel <= '{pixel_row: row, pixel_col: col};
		@(posedge clk);
		while (!pixel_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		pixel_valid <= 0;
		while (sb.pending_rays.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [47:0] d);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	function automatic logic [47:0] rand_basis();
		logic [47:0] b;
		for (int k = 0; k < 3; k++)
			b[16*k +: 16] = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(32768) - 16384);
		return b;
	endfunction

	task automatic random_config();
		write_reg(crg_pkg::CFG_BASIS_U, rand_basis());
		write_reg(crg_pkg::CFG_BASIS_V, rand_basis());
		write_reg(crg_pkg::CFG_BASIS_W, rand_basis());
		write_reg(crg_pkg::CFG_CAM_X,
			48'($urandom_range(1) ? $urandom : $urandom_range(1 << 20)));
		write_reg(crg_pkg::CFG_CAM_Y, 48'($urandom));
		write_reg(crg_pkg::CFG_CAM_Z, 48'($urandom_range(1) ? $urandom : 0));
		write_reg(crg_pkg::CFG_VIEWPORT, $urandom_range(1) ? 48'({$urandom, $urandom}) :
			{16'($urandom_range(2048)), 16'($urandom_range(2048)), 16'($urandom_range(2048))});
	endtask

	initial begin
		sb = new();
		cycles = 0;
		arst_n = 0;
		pixel = '0;
		pixel_valid = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: defaults, image corners, out-of-image pixels
		send_pixel(0, 0);
		send_pixel(1023, 767);
		send_pixel(511, 384);
		send_pixel(1023, 0);
		send_pixel(0, 767);
		send_pixel(1023, 1023);
		send_pixel(10'h2AA, 10'h155);
		send_pixel(10'h155, 10'h2AA);
		drain();
		// zero direction: zero basis with camera offset
		write_reg(crg_pkg::CFG_BASIS_U, 0);
		write_reg(crg_pkg::CFG_BASIS_V, 0);
		write_reg(crg_pkg::CFG_BASIS_W, 0);
		write_reg(crg_pkg::CFG_CAM_X, 32'h8000_0000);
		write_reg(crg_pkg::CFG_CAM_Y, 32'h7FFF_FFFF);
		write_reg(crg_pkg::CFG_CAM_Z, 32'h0001_0000);
		write_reg(7, 48'hFFFF_FFFF_FFFF); // out-of-range index is ignored
		send_pixel(0, 0);
		send_pixel(1023, 767);
		drain();
		// saturation: extreme basis and viewport
		write_reg(crg_pkg::CFG_BASIS_U, 48'h8000_8000_8000);
		write_reg(crg_pkg::CFG_BASIS_V, 48'h7FFF_7FFF_7FFF);
		write_reg(crg_pkg::CFG_BASIS_W, 48'h8000_7FFF_8000);
		write_reg(crg_pkg::CFG_VIEWPORT, 48'hFFFF_FFFF_FFFF);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(511, 767);
		drain();
		write_reg(crg_pkg::CFG_VIEWPORT, 0);
		send_pixel(100, 100);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 71; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 71; end
				default: begin send_idle_pct = 15; stall_pct = 15; end
			endcase
			random_config();
			for (int i = 0; i < 125; i++) begin
				if ($urandom_range(3) == 0)
					send_pixel(10'($urandom), 10'($urandom));
				else
					send_pixel(10'($urandom_range(1023)), 10'($urandom_range(767)));
				if (i == 60 && ph == 3) begin
					// the word just sent is still in flight, so this waits at least once
					pixel_valid <= 0;
					while (sb.pending_rays.size() != 0) @(negedge clk);
				end
			end
			drain();
		end

		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
